// ===== rtl/fqd_pkg.sv =====
// Package of the linked-list FIFO queue with delete.
// Holds the sizing constants and the operation codes; depends on nothing.
package fqd_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned SLOT_BITS  = $clog2(DEPTH);
  localparam int unsigned CNT_BITS   = $clog2(DEPTH + 1);

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned IN_VAL_W   = 32;
  localparam int unsigned OUT_VAL_W  = 32;
  localparam int unsigned OUT_CNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_DEL = 2'd2
  } mode_e;

endpackage

// ===== rtl/fqd_in_if.sv =====
// Input channel of the queue: one operation per item.
// Depends on fqd_pkg for the field widths.
interface fqd_in_if;
  logic                           valid;
  logic                           ready;
  logic [fqd_pkg::MODE_W-1:0]     mode;
  logic [fqd_pkg::IN_VAL_W-1:0]   item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink   (input valid, input mode, input item_value, output ready);
endinterface

// ===== rtl/fqd_out_if.sv =====
// Result channel of the queue: one status item per operation.
// Depends on fqd_pkg for the field widths.
interface fqd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [fqd_pkg::OUT_VAL_W-1:0]  item_out;
  logic [fqd_pkg::OUT_CNT_W-1:0]  count;

  modport source (output valid, output status, output item_out, output count, input ready);
  modport sink   (input valid, input status, input item_out, input count, output ready);
endinterface

// ===== rtl/fqd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module fqd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fifo_queue_with_delete_core.sv =====
// FIFO queue of nonzero tokens kept as a linked list in two RAMs (values and links).
// Enqueue, and any error seen at acceptance (zero token, empty or full queue, unused mode):
// result in the cycle after acceptance, one item per cycle while results are taken.
// Dequeue: the head slot is read from the RAMs, then ST_DEQ registers the result. Delete,
// found or not: ST_WALK visits entries from the head, at most DEPTH. Reset is asynchronous
// and empties the queue. Depends on fqd_pkg, fqd_in_if, fqd_out_if and fqd_ram.
module fifo_queue_with_delete_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  fqd_in_if.sink    in_i,
  fqd_out_if.source out_o
);

  localparam int unsigned DEPTH = fqd_pkg::DEPTH;
  localparam int unsigned VW    = fqd_pkg::VALUE_BITS;
  localparam int unsigned SW    = fqd_pkg::SLOT_BITS;
  localparam int unsigned CW    = fqd_pkg::CNT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEQ,
    ST_WALK
  } state_e;

  // Control state. The RAM contents are only ever read for slots on the list,
  // so they need no reset.
  state_e            state_q, state_d;
  logic [DEPTH-1:0]  free_q, free_d;
  logic [SW-1:0]     head_q, head_d;
  logic [SW-1:0]     tail_q, tail_d;
  logic [CW-1:0]     count_q, count_d;

  // Walk registers of a delete: the slot under inspection, its predecessor,
  // how many entries have been passed and the token searched for.
  logic [SW-1:0]     cur_q, cur_d;
  logic [SW-1:0]     prev_q, prev_d;
  logic [CW-1:0]     step_q, step_d;
  logic [VW-1:0]     target_q, target_d;

  // Output register, which decouples the result side from the input side.
  logic                           ovalid_q, ovalid_d;
  logic                           ostatus_q, ostatus_d;
  logic [fqd_pkg::OUT_VAL_W-1:0]  oitem_q, oitem_d;

  // RAM ports.
  logic          val_we, lnk_we, rd_en;
  logic [SW-1:0] val_waddr, lnk_waddr, rd_addr;
  logic [VW-1:0] val_wdata, rd_value;
  logic [SW-1:0] lnk_wdata, rd_link;

  fqd_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_value)
  );

  fqd_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_link)
  );

  // The incoming token, cut or widened to the stored value width.
  logic [63:0]   in_wide;
  logic [VW-1:0] in_val;
  assign in_wide = 64'(in_i.item_value);
  assign in_val  = in_wide[VW-1:0];

  // The output register is free when it is empty or being emptied this cycle.
  logic out_free;
  assign out_free = !ovalid_q || out_o.ready;

  // A new item is taken only between operations and when a result can be stored.
  logic accept;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept     = in_i.valid && in_i.ready;

  // Lowest-numbered free slot for an enqueue.
  logic [SW-1:0] free_slot;
  logic          free_found;
  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int unsigned s = 0; s < DEPTH; s++) begin
      if (free_q[s] && !free_found) begin
        free_slot  = SW'(s);
        free_found = 1'b1;
      end
    end
  end

  logic          full, empty, match;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] step_inc;
  logic [63:0]   rd_wide;
  assign full      = count_q >= CW'(DEPTH);
  assign empty     = count_q == '0;
  assign match     = rd_value == target_q;
  assign count_dec = count_q - CW'(1);
  assign step_inc  = step_q + CW'(1);
  assign rd_wide   = 64'(rd_value);

  always_comb begin
    state_d   = state_q;
    free_d    = free_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    step_d    = step_q;
    target_d  = target_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    ostatus_d = ostatus_q;
    oitem_d   = oitem_q;

    val_we    = 1'b0;
    val_waddr = free_slot;
    val_wdata = in_val;
    lnk_we    = 1'b0;
    lnk_waddr = tail_q;
    lnk_wdata = free_slot;
    rd_en     = 1'b0;
    rd_addr   = head_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // Every path that finishes here gives an error or an enqueue result.
          ovalid_d  = 1'b1;
          ostatus_d = 1'b1;
          oitem_d   = '0;
          case (in_i.mode)
            fqd_pkg::MODE_ENQ: begin
              if (in_val != '0 && !full && free_found) begin
                ostatus_d         = 1'b0;
                val_we            = 1'b1;
                free_d[free_slot] = 1'b0;
                // The old tail now points at the new entry.
                lnk_we            = !empty;
                if (empty) begin
                  head_d = free_slot;
                end
                tail_d  = free_slot;
                count_d = count_q + CW'(1);
              end
            end
            fqd_pkg::MODE_DEQ: begin
              if (!empty) begin
                ovalid_d = 1'b0;
                rd_en    = 1'b1;
                state_d  = ST_DEQ;
              end
            end
            fqd_pkg::MODE_DEL: begin
              if (in_val != '0 && !empty) begin
                ovalid_d = 1'b0;
                rd_en    = 1'b1;
                cur_d    = head_q;
                prev_d   = '0;
                step_d   = '0;
                target_d = in_val;
                state_d  = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_DEQ: begin
        // Head value and link have arrived from the RAMs.
        ovalid_d       = 1'b1;
        ostatus_d      = 1'b0;
        oitem_d        = rd_wide[fqd_pkg::OUT_VAL_W-1:0];
        free_d[head_q] = 1'b1;
        count_d        = count_dec;
        if (count_dec == '0) begin
          head_d = '0;
          tail_d = '0;
        end else begin
          head_d = rd_link;
        end
        state_d = ST_IDLE;
      end

      ST_WALK: begin
        if (match) begin
          // Unlink the entry: either the head moves on, or the predecessor
          // skips over it.
          ovalid_d  = 1'b1;
          ostatus_d = 1'b0;
          oitem_d   = '0;
          if (step_q == '0) begin
            head_d = rd_link;
          end else begin
            lnk_we    = 1'b1;
            lnk_waddr = prev_q;
            lnk_wdata = rd_link;
          end
          if (cur_q == tail_q) begin
            tail_d = prev_q;
          end
          free_d[cur_q] = 1'b1;
          count_d       = count_dec;
          if (count_dec == '0) begin
            head_d = '0;
            tail_d = '0;
          end
          state_d = ST_IDLE;
        end else if (step_inc < count_q) begin
          // Follow the link to the next entry.
          rd_en   = 1'b1;
          rd_addr = rd_link;
          prev_d  = cur_q;
          cur_d   = rd_link;
          step_d  = step_inc;
        end else begin
          // The whole list was passed without a match.
          ovalid_d  = 1'b1;
          ostatus_d = 1'b1;
          oitem_d   = '0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      free_q    <= '1;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      cur_q     <= '0;
      prev_q    <= '0;
      step_q    <= '0;
      target_q  <= '0;
      ovalid_q  <= 1'b0;
      ostatus_q <= 1'b0;
      oitem_q   <= '0;
    end else begin
      state_q   <= state_d;
      free_q    <= free_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      cur_q     <= cur_d;
      prev_q    <= prev_d;
      step_q    <= step_d;
      target_q  <= target_d;
      ovalid_q  <= ovalid_d;
      ostatus_q <= ostatus_d;
      oitem_q   <= oitem_d;
    end
  end

  // The count travels with the result; it is the count after the operation,
  // which the count register holds while the result waits.
  logic [31:0] count_wide;
  assign count_wide = 32'(count_q);

  assign out_o.valid    = ovalid_q;
  assign out_o.status   = ostatus_q;
  assign out_o.item_out = oitem_q;
  assign out_o.count    = count_wide[fqd_pkg::OUT_CNT_W-1:0];

endmodule
